FILE: hdl/cbt_pkg.sv
// Package for the consumption budget tracker: widths, codes, queue entry type.
// Shared by the front end, the queue, the executor, the top level and the checker.
// No dependencies.
`default_nettype none

package cbt_pkg;

   // Table and key sizing
   localparam int RATE_SLOTS  = 16;
   localparam int ID_BITS     = 16;
   localparam int KEY_BITS    = ID_BITS + 1;
   localparam int SLOT_BITS   = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
   localparam int COUNT_BITS  = $clog2(RATE_SLOTS + 1);

   // Field widths
   localparam int MODE_BITS     = 3;
   localparam int ID_FIELD_BITS = 16;
   localparam int AMOUNT_BITS   = 32;
   localparam int STEPS_BITS    = 16;
   localparam int STATUS_BITS   = 3;
   localparam int CAP_BITS      = 32;
   localparam int ACTIVE_BITS   = 5;

   // Arithmetic widths: sum of all rates, then rates + one-shot + amount
   localparam int RATE_BITS = AMOUNT_BITS + $clog2(RATE_SLOTS);
   localparam int ACC_BITS  = RATE_BITS + 2;

   // Stream packing
   localparam int REQ_PRESENT_LSB = 0;
   localparam int REQ_ID_LSB      = 1;
   localparam int REQ_AMOUNT_LSB  = REQ_ID_LSB + ID_FIELD_BITS;
   localparam int REQ_STEPS_LSB   = REQ_AMOUNT_LSB + AMOUNT_BITS;
   localparam int REQ_DATA_BITS   = 72;
   localparam int RSP_REMAIN_LSB  = 0;
   localparam int RSP_COUNT_LSB   = CAP_BITS;
   localparam int RSP_DATA_BITS   = 40;
   localparam int RSP_PAD_BITS    = RSP_DATA_BITS - CAP_BITS - ACTIVE_BITS;

   // Queue between front end and executor
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;

   // Configuration registers
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_CAPACITY      = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RESERVED_CAPACITY = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_INITIAL_CAPACITY  = 2'd2;

   localparam logic [CAP_BITS-1:0] MAX_CAPACITY_RESET      = 32'd256000;
   localparam logic [CAP_BITS-1:0] RESERVED_CAPACITY_RESET = 32'd0;
   localparam logic [CAP_BITS-1:0] INITIAL_CAPACITY_RESET  = 32'd128000;

   // Mode codes on the request channel
   localparam logic [MODE_BITS-1:0] MODE_ADD_RATE    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE_RATE = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_TRY_ONCE    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_APPLY_ONCE  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_APPLY_UNTIL = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_TICK        = 3'd5;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_REMOVE,
      OP_TRY,
      OP_APPLY,
      OP_UNTIL,
      OP_TICK,
      OP_INVALID
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 3'd0,
      STAT_REFUSED   = 3'd1,
      STAT_IGNORED   = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_OVERRUN   = 3'd5,
      STAT_DEPLETED  = 3'd6
   } status_type;

   // One classified item as it waits in the queue
   typedef struct packed {
      op_type                 op;
      logic [KEY_BITS-1:0]    key;
      logic [AMOUNT_BITS-1:0] amount;
      logic                   amount_zero;
      logic                   steps_zero;
   } entry_type;

endpackage

`default_nettype wire

FILE: hdl/cbt_front.sv
// Front end: takes request items, unpacks them and classifies the mode.
// Depends on cbt_pkg.
`default_nettype none

module cbt_front
   import cbt_pkg::*;
(
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [MODE_BITS-1:0]     req_tuser,
   input  wire logic                     queue_full,
   output      logic                     queue_push,
   output      entry_type                queue_entry
);

   logic                             present;
   logic [ID_FIELD_BITS-1:0]         id_field;
   logic [ID_BITS+ID_FIELD_BITS-1:0] id_wide;
   logic [ID_BITS-1:0]               id;
   logic [STEPS_BITS-1:0]            steps;

   // Unpack the payload
   assign present  = req_tdata[REQ_PRESENT_LSB];
   assign id_field = req_tdata[REQ_ID_LSB +: ID_FIELD_BITS];
   assign steps    = req_tdata[REQ_STEPS_LSB +: STEPS_BITS];
   assign id_wide  = {{ID_BITS{1'b0}}, id_field};
   assign id       = id_wide[ID_BITS-1:0];

   assign req_tready = !queue_full && !reset;
   assign queue_push = req_tvalid && req_tready;

   // Classify: anonymous key is zero, named keys carry a marker bit on top
   always_comb begin
      queue_entry.key         = present ? {1'b1, id} : '0;
      queue_entry.amount      = req_tdata[REQ_AMOUNT_LSB +: AMOUNT_BITS];
      queue_entry.amount_zero = (queue_entry.amount == '0);
      queue_entry.steps_zero  = (steps == '0);
      unique case (req_tuser)
         MODE_ADD_RATE:    queue_entry.op = OP_ADD;
         MODE_REMOVE_RATE: queue_entry.op = OP_REMOVE;
         MODE_TRY_ONCE:    queue_entry.op = OP_TRY;
         MODE_APPLY_ONCE:  queue_entry.op = OP_APPLY;
         MODE_APPLY_UNTIL: queue_entry.op = OP_UNTIL;
         MODE_TICK:        queue_entry.op = OP_TICK;
         default:          queue_entry.op = OP_INVALID;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/cbt_queue.sv
// Short queue of classified items between the front end and the executor.
// Depends on cbt_pkg.
`default_nettype none

module cbt_queue
   import cbt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output      logic      full,
   input  wire logic      pop,
   output      logic      valid,
   output      entry_type pop_entry
);

   entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cbt_exec.sv
// Executor: rate table, budget state, configuration registers and result register.
// Runs each item through a lookup state, then a commit state. Depends on cbt_pkg.
`default_nettype none

module cbt_exec
   import cbt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [CAP_BITS-1:0]      csr_data,
   input  wire logic                     queue_valid,
   input  wire entry_type                queue_entry,
   output      logic                     queue_pop,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output      logic [STATUS_BITS-1:0]   rsp_tuser
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_EXEC
   } state_type;

   // Sequencer and result register
   state_type              state_ff, state_in;
   entry_type              cur_ff, cur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CAP_BITS-1:0]    rsp_remain_ff, rsp_remain_in;
   logic [ACTIVE_BITS-1:0] rsp_active_ff, rsp_active_in;

   // Lookup results, held for the commit cycle
   logic                   hit_ff, hit_in;
   logic [SLOT_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic                   free_ok_ff, free_ok_in;
   logic [SLOT_BITS-1:0]   free_idx_ff, free_idx_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [ACC_BITS-1:0]    tick_ff, tick_in;
   logic [CAP_BITS:0]      head_ff, head_in;

   // Budget state and configuration
   logic [RATE_SLOTS-1:0]  valid_ff, valid_in;
   logic [KEY_BITS-1:0]    key_ff [RATE_SLOTS];
   logic [AMOUNT_BITS-1:0] rate_ff [RATE_SLOTS];
   logic [RATE_BITS-1:0]   rate_total_ff, rate_total_in;
   logic [AMOUNT_BITS-1:0] one_shot_ff, one_shot_in;
   logic [CAP_BITS-1:0]    cap_left_ff, cap_left_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CAP_BITS-1:0]    max_cap_ff, max_cap_in;
   logic [CAP_BITS-1:0]    reserved_ff, reserved_in;
   logic [CAP_BITS-1:0]    initial_ff, initial_in;

   // Table write port
   logic                   tbl_we;
   logic [SLOT_BITS-1:0]   tbl_idx;

   // Combinational helpers
   logic                   match_hit;
   logic [SLOT_BITS-1:0]   match_idx;
   logic                   free_hit;
   logic [SLOT_BITS-1:0]   free_idx;
   logic                   out_free;
   logic                   acc_le;
   logic                   tick_le;
   logic                   tick_eq;
   logic [AMOUNT_BITS:0]   once_sum;
   logic [COUNT_BITS+ACTIVE_BITS-1:0] active_wide;
   status_type             status;

   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_active_ff, rsp_remain_ff};

   // Key match and lowest free slot; lowest index wins
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      free_hit  = 1'b0;
      free_idx  = '0;
      for (int i = RATE_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == cur_ff.key)) begin
            match_hit = 1'b1;
            match_idx = SLOT_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   // Headroom compares; a negative headroom fails every test
   assign acc_le   = !head_ff[CAP_BITS] && (acc_ff <= ACC_BITS'(head_ff[CAP_BITS-1:0]));
   assign tick_le  = !head_ff[CAP_BITS] && (tick_ff <= ACC_BITS'(head_ff[CAP_BITS-1:0]));
   assign tick_eq  = !head_ff[CAP_BITS] && (tick_ff == ACC_BITS'(head_ff[CAP_BITS-1:0]));
   assign once_sum = {1'b0, one_shot_ff} + {1'b0, cur_ff.amount};
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer and item execution
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_remain_in = rsp_remain_ff;
      rsp_active_in = rsp_active_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      acc_in        = acc_ff;
      tick_in       = tick_ff;
      head_in       = head_ff;
      valid_in      = valid_ff;
      rate_total_in = rate_total_ff;
      one_shot_in   = one_shot_ff;
      cap_left_in   = cap_left_ff;
      count_in      = count_ff;
      max_cap_in    = max_cap_ff;
      reserved_in   = reserved_ff;
      initial_in    = initial_ff;
      tbl_we        = 1'b0;
      tbl_idx       = free_idx_ff;
      queue_pop     = 1'b0;
      status        = STAT_OK;
      active_wide   = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               cur_in    = queue_entry;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            hit_in      = match_hit;
            hit_idx_in  = match_idx;
            free_ok_in  = free_hit;
            free_idx_in = free_idx;
            tick_in     = ACC_BITS'(rate_total_ff) + ACC_BITS'(one_shot_ff);
            acc_in      = ACC_BITS'(rate_total_ff) + ACC_BITS'(one_shot_ff)
                          + ACC_BITS'(cur_ff.amount);
            head_in     = {1'b0, max_cap_ff} - {1'b0, reserved_ff};
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               unique case (cur_ff.op)
                  OP_ADD: begin
                     if (cur_ff.amount_zero) begin
                        status = STAT_IGNORED;
                     end else if (hit_ff) begin
                        // Replace the rate of an existing consumer
                        tbl_we        = 1'b1;
                        tbl_idx       = hit_idx_ff;
                        rate_total_in = rate_total_ff - RATE_BITS'(rate_ff[hit_idx_ff])
                                        + RATE_BITS'(cur_ff.amount);
                     end else if (free_ok_ff) begin
                        tbl_we                = 1'b1;
                        tbl_idx               = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        rate_total_in = rate_total_ff + RATE_BITS'(cur_ff.amount);
                        count_in      = count_ff + COUNT_BITS'(1);
                     end else begin
                        status = STAT_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        rate_total_in = rate_total_ff - RATE_BITS'(rate_ff[hit_idx_ff]);
                        count_in      = count_ff - COUNT_BITS'(1);
                     end else begin
                        status = STAT_NOT_FOUND;
                     end
                  end
                  OP_TRY: begin
                     status = acc_le ? STAT_OK : STAT_REFUSED;
                  end
                  OP_APPLY: begin
                     // Saturating one-shot accumulator
                     one_shot_in = once_sum[AMOUNT_BITS] ? '1 : once_sum[AMOUNT_BITS-1:0];
                  end
                  OP_UNTIL: begin
                     // max - acc >= reserved is the same test as acc <= headroom
                     if (!cur_ff.steps_zero) begin
                        if (acc_le) begin
                           cap_left_in = max_cap_ff - acc_ff[CAP_BITS-1:0];
                        end else begin
                           cap_left_in = reserved_ff;
                           status      = STAT_REFUSED;
                        end
                     end
                  end
                  OP_TICK: begin
                     if (!tick_le) begin
                        status = STAT_OVERRUN;
                     end else begin
                        cap_left_in = max_cap_ff - tick_ff[CAP_BITS-1:0];
                        one_shot_in = '0;
                        status      = tick_eq ? STAT_DEPLETED : STAT_OK;
                     end
                  end
                  default: begin
                     status = STAT_REFUSED;
                  end
               endcase

               active_wide   = {{ACTIVE_BITS{1'b0}}, count_in};
               rsp_valid_in  = 1'b1;
               rsp_status_in = status;
               rsp_remain_in = cap_left_in;
               rsp_active_in = active_wide[ACTIVE_BITS-1:0];

               // Go straight on to the next waiting item
               if (queue_valid) begin
                  queue_pop = 1'b1;
                  cur_in    = queue_entry;
                  state_in  = S_LOOK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes: host must issue these only with no item in flight (unchecked)
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_CAPACITY:      max_cap_in  = csr_data;
            CSR_RESERVED_CAPACITY: reserved_in = csr_data;
            CSR_INITIAL_CAPACITY: begin
               initial_in  = csr_data;
               cap_left_in = csr_data;
            end
            default: ;
         endcase
      end
   end

   // State, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         rate_total_ff <= '0;
         one_shot_ff   <= '0;
         cap_left_ff   <= INITIAL_CAPACITY_RESET;
         count_ff      <= '0;
         max_cap_ff    <= MAX_CAPACITY_RESET;
         reserved_ff   <= RESERVED_CAPACITY_RESET;
         initial_ff    <= INITIAL_CAPACITY_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         rate_total_ff <= rate_total_in;
         one_shot_ff   <= one_shot_in;
         cap_left_ff   <= cap_left_in;
         count_ff      <= count_in;
         max_cap_ff    <= max_cap_in;
         reserved_ff   <= reserved_in;
         initial_ff    <= initial_in;
      end
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_remain_ff <= rsp_remain_in;
      rsp_active_ff <= rsp_active_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      acc_ff        <= acc_in;
      tick_ff       <= tick_in;
      head_ff       <= head_in;
   end

   // Rate table payload, no reset
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         key_ff[tbl_idx]  <= cur_ff.key;
         rate_ff[tbl_idx] <= cur_ff.amount;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/consumption_budget_tracker_top.sv
// Top level of the consumption budget tracker: front end, queue and executor.
// Depends on cbt_pkg, cbt_front, cbt_queue and cbt_exec.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tdata: present, id, amount, steps; tuser: mode
//   rsp      out        rsp_tvalid/tready     tdata: remaining, active_rates; tuser: status
//   csr      in         csr_valid/ready       csr_index, csr_data
//
// The executor handles each item as a table lookup followed by a commit, and takes
// the next item only as the current one commits; a stalled result holds the commit.
// Reset is synchronous; there is no clearing pass.
// A two-entry queue lets the front keep taking items while the executor waits
// on a stalled result register.
`default_nettype none

module consumption_budget_tracker_top
   import cbt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Fields from bit 0: consumer_present, consumer_id, amount, steps, zero pad
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // Fields: mode
   input  wire logic [MODE_BITS-1:0]     req_tuser,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // Fields from bit 0: remaining, active_rates, zero pad
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Fields: status
   output      logic [STATUS_BITS-1:0]   rsp_tuser,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [CAP_BITS-1:0]      csr_data
);

   logic      queue_full;
   logic      queue_push;
   entry_type push_entry;
   logic      queue_pop;
   logic      queue_valid;
   entry_type pop_entry;

   cbt_front u_front (
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   cbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .valid      (queue_valid),
      .pop_entry  (pop_entry)
   );

   cbt_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_valid (queue_valid),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: hdl/cbt_checker.sv
// Port-level checks for the consumption budget tracker, bound to the top level.
// Depends on cbt_pkg and consumption_budget_tracker_top.
`default_nettype none

module cbt_checker
   import cbt_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [STATUS_BITS-1:0]   rsp_tuser,
   input wire logic                     csr_ready
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Nothing is taken in while reset is held
   a_reset_no_ready: assert property (@(posedge clock)
      reset |-> !req_tready && !csr_ready)
      else $error("ready raised during reset");

   // Table full is only reported when every slot is in use
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_FULL)
      |-> rsp_tdata[RSP_COUNT_LSB +: ACTIVE_BITS] == ACTIVE_BITS'(RATE_SLOTS))
      else $error("table full reported with free slots");

endmodule

bind consumption_budget_tracker_top cbt_checker u_checker (.*);

`default_nettype wire
